// ===== hdl/mwrs_pkg.sv =====
package mwrs_pkg;

  localparam int DEF_MAX_ENTRIES = 32;
  localparam int DEF_WEIGHT_BITS = 16;

  localparam int MASK_BITS = 32;
  localparam int CNT_W     = 6;
  localparam int POS_W     = 5;
  localparam int FRAC_W    = 16;
  localparam int IN_WT_W   = 16;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic add;
    logic mul;
    logic load_frac;
  } dp_ctrl_t;

  typedef struct packed {
    logic acc_zero;
    logic hit;
  } dp_stat_t;

endpackage

// ===== hdl/masked_weighted_random_select.sv =====
// Channel  Handshake           Payload
// in       in_valid/in_stall   opcode, entry_index, entry_weight, exclude_mask,
//                              active_count, random_fraction
// out      out_valid/out_stall chosen_index, none_found
//
// A load request writes the weight memory directly.
// A select request makes one memory read per entry in the total pass, then a
// multiply step, then one read per entry in the scan, all through a single
// shared adder and the one memory read port.
// The input stalls until the result is in the output register; the next request
// is taken while that result still waits. Reset is synchronous and clears control
// state only; the weight memory holds no defined value until written.
module masked_weighted_random_select #(
  parameter int MAX_ENTRIES = mwrs_pkg::DEF_MAX_ENTRIES,
  parameter int WEIGHT_BITS = mwrs_pkg::DEF_WEIGHT_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [mwrs_pkg::POS_W-1:0]        entry_index,
  input  logic [mwrs_pkg::IN_WT_W-1:0]      entry_weight,
  input  logic [mwrs_pkg::MASK_BITS-1:0]    exclude_mask,
  input  logic [mwrs_pkg::CNT_W-1:0]        active_count,
  input  logic [mwrs_pkg::FRAC_W-1:0]       random_fraction,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mwrs_pkg::POS_W-1:0]        chosen_index,
  output logic                              none_found
);
  import mwrs_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [WEIGHT_BITS-1:0] wr_data;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [WEIGHT_BITS-1:0] rd_data;
  dp_ctrl_t               dp_ctl;
  dp_stat_t               dp_stat;

  mwrs_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .WEIGHT_BITS(WEIGHT_BITS),
    .IDX_W(IDX_W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .entry_index(entry_index),
    .entry_weight(entry_weight),
    .exclude_mask(exclude_mask),
    .active_count(active_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .chosen_index(chosen_index),
    .none_found(none_found),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .dp_ctl(dp_ctl),
    .dp_stat(dp_stat)
  );

  mwrs_wmem #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .WEIGHT_BITS(WEIGHT_BITS),
    .IDX_W(IDX_W)
  ) u_wmem (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  mwrs_dp #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_dp (
    .clk(clk),
    .ctl(dp_ctl),
    .frac_in(random_fraction),
    .rd_data(rd_data),
    .stat(dp_stat)
  );

endmodule

// ===== hdl/mwrs_wmem.sv =====
module mwrs_wmem #(
  parameter int MAX_ENTRIES = 32,
  parameter int WEIGHT_BITS = 16,
  parameter int IDX_W       = 5
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [IDX_W-1:0]       wr_addr,
  input  logic [WEIGHT_BITS-1:0] wr_data,
  input  logic                   rd_en,
  input  logic [IDX_W-1:0]       rd_addr,
  output logic [WEIGHT_BITS-1:0] rd_data
);

  logic [WEIGHT_BITS-1:0] mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/mwrs_dp.sv =====
module mwrs_dp #(
  parameter int WEIGHT_BITS = 16
) (
  input  logic                           clk,
  input  mwrs_pkg::dp_ctrl_t             ctl,
  input  logic [mwrs_pkg::FRAC_W-1:0]    frac_in,
  input  logic [WEIGHT_BITS-1:0]         rd_data,
  output mwrs_pkg::dp_stat_t             stat
);
  import mwrs_pkg::*;

  localparam int SUM_W  = WEIGHT_BITS + CNT_W;
  localparam int PROD_W = SUM_W + FRAC_W;

  logic [SUM_W-1:0]  acc;
  logic [SUM_W-1:0]  acc_next;
  logic [FRAC_W-1:0] frac;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  thresh;

  // One adder serves both the total pass and the running-sum scan.
  assign acc_next = acc + SUM_W'(rd_data);
  assign thresh   = prod[PROD_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (ctl.load_frac) begin
      frac <= frac_in;
    end
    if (ctl.mul) begin
      prod <= PROD_W'(acc) * PROD_W'(frac);
    end
    if (ctl.clr) begin
      acc <= '0;
    end else if (ctl.add) begin
      acc <= acc_next;
    end
  end

  always_comb begin
    stat.acc_zero = (acc == '0);
    stat.hit      = (thresh <= acc_next);
  end

endmodule

// ===== hdl/mwrs_ctrl.sv =====
module mwrs_ctrl #(
  parameter int MAX_ENTRIES = 32,
  parameter int WEIGHT_BITS = 16,
  parameter int IDX_W       = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [mwrs_pkg::POS_W-1:0]        entry_index,
  input  logic [mwrs_pkg::IN_WT_W-1:0]      entry_weight,
  input  logic [mwrs_pkg::MASK_BITS-1:0]    exclude_mask,
  input  logic [mwrs_pkg::CNT_W-1:0]        active_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mwrs_pkg::POS_W-1:0]        chosen_index,
  output logic                              none_found,
  output logic                              wr_en,
  output logic [IDX_W-1:0]                  wr_addr,
  output logic [WEIGHT_BITS-1:0]            wr_data,
  output logic                              rd_en,
  output logic [IDX_W-1:0]                  rd_addr,
  output mwrs_pkg::dp_ctrl_t                dp_ctl,
  input  mwrs_pkg::dp_stat_t                dp_stat
);
  import mwrs_pkg::*;

  localparam int LIMIT = (MAX_ENTRIES < MASK_BITS) ? MAX_ENTRIES : MASK_BITS;

  state_t               state, state_next;
  logic [CNT_W-1:0]     pos, pos_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [MASK_BITS-1:0] mask, mask_next;
  logic                 rd_act, rd_act_next;
  logic [POS_W-1:0]     rd_pos, rd_pos_next;
  logic [POS_W-1:0]     res_idx, res_idx_next;
  logic                 res_none, res_none_next;
  logic                 out_valid_next;
  logic [POS_W-1:0]     chosen_index_next;
  logic                 none_found_next;
  logic                 accept;
  logic                 issue;
  logic [CNT_W-1:0]     cnt_sat;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cnt_sat  = (int'(active_count) > LIMIT) ? CNT_W'(LIMIT) : active_count;

  assign wr_en   = accept && (opcode == OP_LOAD) && (int'(entry_index) < MAX_ENTRIES);
  assign wr_addr = IDX_W'(entry_index);
  assign wr_data = WEIGHT_BITS'(entry_weight);

  assign issue   = ((state == ST_SUM) || (state == ST_SCAN)) && (pos < cnt);
  assign rd_en   = issue;
  assign rd_addr = IDX_W'(pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      rd_act    <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      rd_act    <= rd_act_next;
    end
    pos          <= pos_next;
    cnt          <= cnt_next;
    mask         <= mask_next;
    rd_pos       <= rd_pos_next;
    res_idx      <= res_idx_next;
    res_none     <= res_none_next;
    chosen_index <= chosen_index_next;
    none_found   <= none_found_next;
  end

  always_comb begin
    state_next        = state;
    pos_next          = pos;
    cnt_next          = cnt;
    mask_next         = mask;
    rd_act_next       = 1'b0;
    rd_pos_next       = rd_pos;
    res_idx_next      = res_idx;
    res_none_next     = res_none;
    out_valid_next    = out_valid && out_stall;
    chosen_index_next = chosen_index;
    none_found_next   = none_found;
    dp_ctl            = '0;

    if (issue) begin
      pos_next    = pos + CNT_W'(1);
      rd_act_next = !mask[pos[POS_W-1:0]];
      rd_pos_next = pos[POS_W-1:0];
    end

    case (state)
      ST_IDLE: begin
        if (accept && (opcode == OP_SELECT)) begin
          mask_next         = exclude_mask;
          cnt_next          = cnt_sat;
          pos_next          = '0;
          dp_ctl.clr        = 1'b1;
          dp_ctl.load_frac  = 1'b1;
          state_next        = ST_SUM;
        end
      end
      ST_SUM: begin
        dp_ctl.add = rd_act;
        if (!issue && !rd_act) begin
          if (dp_stat.acc_zero) begin
            res_idx_next  = '0;
            res_none_next = 1'b1;
            state_next    = ST_DONE;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        dp_ctl.mul = 1'b1;
        dp_ctl.clr = 1'b1;
        pos_next   = '0;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        dp_ctl.add = rd_act;
        if (rd_act && dp_stat.hit) begin
          res_idx_next  = rd_pos;
          res_none_next = 1'b0;
          rd_act_next   = 1'b0;
          state_next    = ST_DONE;
        end else if (!issue && !rd_act) begin
          res_idx_next  = '0;
          res_none_next = 1'b1;
          state_next    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next    = 1'b1;
          chosen_index_next = res_idx;
          none_found_next   = res_none;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mwrs_pkg::*;

  localparam int NUM_ENTRIES = 32;
  localparam int RANDOM_REQUESTS = 1280;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic        op;
    logic [4:0]  idx;
    logic [15:0] wt;
    logic [31:0] mask;
    logic [5:0]  cnt;
    logic [15:0] frac;
    logic        typed;
    logic [4:0]  exp_idx;
    logic        exp_none;
  } request_t;

  typedef struct {
    logic [4:0] idx;
    logic       none;
  } pick_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = OP_LOAD;
  logic [4:0]  entry_index = '0;
  logic [15:0] entry_weight = '0;
  logic [31:0] exclude_mask = '0;
  logic [5:0]  active_count = '0;
  logic [15:0] random_fraction = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  chosen_index;
  logic        none_found;

  logic        req_typed = 1'b0;
  logic [4:0]  req_exp_idx = '0;
  logic        req_exp_none = 1'b0;

  logic [15:0] weight_copy [NUM_ENTRIES];
  pick_t       pending_picks [$];
  request_t    script [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          stall_window = 0;

  masked_weighted_random_select dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .entry_index     (entry_index),
    .entry_weight    (entry_weight),
    .exclude_mask    (exclude_mask),
    .active_count    (active_count),
    .random_fraction (random_fraction),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .chosen_index    (chosen_index),
    .none_found      (none_found)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic pick_t pick_entry(logic [31:0] mask, logic [5:0] cnt,
                                       logic [15:0] frac);
    logic [36:0] total;
    logic [36:0] thresh;
    logic [36:0] run;
    int          n;
    pick_t       r;
    n = (cnt > NUM_ENTRIES) ? NUM_ENTRIES : int'(cnt);
    total = '0;
    run = '0;
    r.idx = '0;
    r.none = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (!mask[i]) total += 37'(weight_copy[i]);
    end
    if (total == 0) return r;
    thresh = (total * 37'(frac)) >> 16;
    for (int i = 0; i < n; i++) begin
      if (!mask[i]) begin
        run += 37'(weight_copy[i]);
        if (thresh <= run) begin
          r.idx = 5'(i);
          r.none = 1'b0;
          return r;
        end
      end
    end
    return r;
  endfunction

  function automatic request_t row(logic op, logic [4:0] idx, logic [15:0] wt,
                                   logic [31:0] mask, logic [5:0] cnt, logic [15:0] frac,
                                   logic typed, logic [4:0] exp_idx, logic exp_none);
    request_t r;
    r.op = op;
    r.idx = idx;
    r.wt = wt;
    r.mask = mask;
    r.cnt = cnt;
    r.frac = frac;
    r.typed = typed;
    r.exp_idx = exp_idx;
    r.exp_none = exp_none;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    r = row(OP_SELECT, 5'($urandom), 16'($urandom), 32'($urandom), '0, 16'($urandom),
            1'b0, '0, 1'b0);
    if ($urandom_range(0, 9) < 3) begin
      r.op = OP_LOAD;
      case ($urandom_range(0, 9))
        0, 1: r.wt = '0;
        2: r.wt = 16'hFFFF;
        3, 4: r.wt = 16'($urandom_range(0, 15));
        default: r.wt = 16'($urandom);
      endcase
    end else begin
      case ($urandom_range(0, 9))
        0: r.cnt = 6'($urandom_range(33, 63));
        1, 2: r.cnt = 6'd32;
        default: r.cnt = 6'($urandom_range(0, 32));
      endcase
      case ($urandom_range(0, 9))
        0: r.mask = '0;
        1: r.mask = '1;
        2, 3: r.mask = 32'($urandom) & 32'($urandom) & 32'($urandom);
        4, 5: r.mask = 32'($urandom) | 32'($urandom) | 32'($urandom);
        default: r.mask = 32'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0: r.frac = '0;
        1: r.frac = 16'hFFFF;
        default: r.frac = 16'($urandom);
      endcase
    end
    return r;
  endfunction

  task automatic send_request(input request_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    opcode <= r.op;
    entry_index <= r.idx;
    entry_weight <= r.wt;
    exclude_mask <= r.mask;
    active_count <= r.cnt;
    random_fraction <= r.frac;
    req_typed <= r.typed;
    req_exp_idx <= r.exp_idx;
    req_exp_none <= r.exp_none;
    do @(posedge clk); while (in_stall);
  endtask

  always @(posedge clk) begin
    pick_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        if (opcode == OP_LOAD) begin
          weight_copy[entry_index] = entry_weight;
        end else if (req_typed) begin
          want.idx = req_exp_idx;
          want.none = req_exp_none;
          pending_picks.push_back(want);
        end else begin
          pending_picks.push_back(pick_entry(exclude_mask, active_count, random_fraction));
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_picks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: chosen_index=%0d none_found=%0b",
                     chosen_index, none_found);
        end else begin
          want = pending_picks.pop_front();
          if (chosen_index !== want.idx || none_found !== want.none) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected index=%0d none=%0b, got index=%0d none=%0b",
                       want.idx, want.none, chosen_index, none_found);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_window == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_window = $urandom_range(20, 200);
      end else begin
        stall_window--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_window[2];
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[masked_weighted_random_select] ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      weight_copy[i] = '0;
      script.push_back(row(OP_LOAD, 5'(i), 16'($urandom), '0, '0, '0, 1'b0, '0, 1'b0));
    end
    script.push_back(row(OP_LOAD, 5'd0, 16'hFFFF, '0, '0, '0, 1'b0, '0, 1'b0));
    script.push_back(row(OP_LOAD, 5'd1, 16'h0000, '0, '0, '0, 1'b0, '0, 1'b0));
    script.push_back(row(OP_LOAD, 5'd2, 16'h0005, '0, '0, '0, 1'b0, '0, 1'b0));
    script.push_back(row(OP_LOAD, 5'd31, 16'hFFFF, '0, '0, '0, 1'b0, '0, 1'b0));
    // An empty selection window and a fully masked table both report none.
    script.push_back(row(OP_SELECT, '0, '0, 32'h0, 6'd0, 16'h0000, 1'b1, 5'd0, 1'b1));
    script.push_back(row(OP_SELECT, '0, '0, '1, 6'd32, 16'h1234, 1'b1, 5'd0, 1'b1));
    script.push_back(row(OP_SELECT, '0, '0, 32'h1, 6'd2, 16'hFFFF, 1'b1, 5'd0, 1'b1));
    script.push_back(row(OP_SELECT, '0, '0, 32'h0, 6'd1, 16'h0000, 1'b1, 5'd0, 1'b0));
    script.push_back(row(OP_SELECT, '0, '0, 32'h2, 6'd2, 16'hFFFF, 1'b1, 5'd0, 1'b0));
    // A zero threshold picks the first unmasked entry even if its weight is zero.
    script.push_back(row(OP_SELECT, '0, '0, 32'h1, 6'd3, 16'h0000, 1'b1, 5'd1, 1'b0));
    // Counts above the table size saturate to the last entry.
    script.push_back(row(OP_SELECT, '0, '0, 32'h7FFF_FFFF, 6'd63, 16'hFFFF, 1'b1, 5'd31, 1'b0));
    script.push_back(row(OP_SELECT, '0, '0, 32'h7FFF_FFFF, 6'd32, 16'h0000, 1'b1, 5'd31, 1'b0));
    script.push_back(row(OP_SELECT, '0, '0, 32'h0, 6'd33, 16'hFFFF, 1'b0, '0, 1'b0));
    script.push_back(row(OP_SELECT, '0, '0, 32'h0, 6'd32, 16'h8000, 1'b0, '0, 1'b0));
    script.push_back(row(OP_SELECT, '0, '0, 32'h8000_0000, 6'd32, 16'hFFFF, 1'b0, '0, 1'b0));
    script.push_back(row(OP_SELECT, '0, '0, 32'hAAAA_AAAA, 6'd31, 16'h5555, 1'b0, '0, 1'b0));
    script.push_back(row(OP_SELECT, '0, '0, 32'h5555_5555, 6'd32, 16'h0001, 1'b0, '0, 1'b0));
    for (int i = 0; i < RANDOM_REQUESTS; i++) script.push_back(random_request());

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (script[i]) send_request(script[i]);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[masked_weighted_random_select] OK");
    end else begin
      $display("[masked_weighted_random_select] ERROR");
    end
    $finish;
  end

endmodule
